// ===== src/bur_pkg.sv =====
// Shared types, constants and helpers of the bounded undo/redo history stack.
`default_nettype none

package bur_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTR_W = $clog2(DEPTH + 1);
   localparam int SUM_W = $clog2(2 * DEPTH);

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_UNDO = 2'd1,
      CMD_REDO = 2'd2,
      CMD_MARK = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_INS_CHAR = 2'd0,
      KIND_DEL_CHAR = 2'd1,
      KIND_INS_NL   = 2'd2,
      KIND_JOIN_ROW = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  edit_kind;
      logic [11:0] cur_line;
      logic [11:0] cur_column;
      logic [11:0] edit_line;
      logic [11:0] edit_column;
      logic [7:0]  char_code;
      logic        made_new_line;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic [1:0]  out_kind;
      logic [11:0] out_cur_line;
      logic [11:0] out_cur_column;
      logic [11:0] out_edit_line;
      logic [11:0] out_edit_column;
      logic [7:0]  out_char;
      logic        out_new_line;
      logic        dirty;
      logic        undo_possible;
      logic        redo_possible;
   } rsp_type;

   // one stored record, 59 bits
   typedef struct packed {
      logic        new_line;
      logic [7:0]  char_code;
      logic [11:0] edit_column;
      logic [11:0] edit_line;
      logic [11:0] cur_column;
      logic [11:0] cur_line;
      logic [1:0]  kind;
   } rec_type;

   // physical slot of a logical position in the ring
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [PTR_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(pos);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic rec_type make_rec(input req_type req);
      rec_type rec;
      rec.kind        = req.edit_kind;
      rec.cur_line    = req.cur_line;
      rec.cur_column  = req.cur_column;
      rec.edit_line   = req.edit_line;
      rec.edit_column = req.edit_column;
      rec.char_code   = req.char_code;
      rec.new_line    = req.made_new_line;
      if (req.edit_kind != KIND_INS_CHAR) begin
         rec.new_line = 1'b0;
      end
      if (req.edit_kind == KIND_INS_NL) begin
         rec.edit_column = '0;
         rec.char_code   = '0;
      end
      if (req.edit_kind == KIND_JOIN_ROW) begin
         rec.char_code = '0;
      end
      return rec;
   endfunction

endpackage

`default_nettype wire

// ===== src/bounded_undo_redo_stack.sv =====
// Top level of the bounded undo/redo history stack.
//
// Commands arrive on req_data and transfer at a rising edge with start high
// and busy low. cmd selects push, undo, redo or mark saved; push takes the
// edit record fields, the others ignore them.
// Every command gives exactly one result on rsp_data, shown with rsp_strobe
// for one cycle, the cycle after the command's transfer. Undo and redo return
// the stepped-over record with entry_valid set; otherwise the record fields
// read zero. dirty, undo_possible and redo_possible reflect the state after
// the command.
// The records sit in a ring memory of DEPTH entries with a registered read
// port; position, entry count, ring base and saved mark are registers
// updated at the transfer edge, so a full store evicts by moving the base.
// A command can be given every cycle and busy stays low, since the memory
// write of a push lands before a following undo reads.
// The receiver cannot stall; each result is taken in its strobe cycle.
// Reset empties the history and sets the saved mark to position zero, so the
// store reads clean; memory contents are left as they are.
`default_nettype none

module bounded_undo_redo_stack
   import bur_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   rec_type          history [DEPTH];

   logic [PTR_W-1:0] pos_ff, pos_in;
   logic [PTR_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [PTR_W-1:0] mark_ff, mark_in;
   logic             mark_ok_ff, mark_ok_in;

   logic             strobe_ff;
   logic             entry_ff, entry_in;
   logic             dirty_ff, undo_ff, redo_ff;
   rec_type          rd_q_ff;

   logic             accept;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_idx, rd_idx;
   logic [PTR_W-1:0] pos_pre;
   logic             mark_ok_pre;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      pos_in      = pos_ff;
      count_in    = count_ff;
      base_in     = base_ff;
      mark_in     = mark_ff;
      mark_ok_in  = mark_ok_ff;
      entry_in    = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      wr_idx      = '0;
      rd_idx      = '0;
      pos_pre     = pos_ff;
      mark_ok_pre = mark_ok_ff;
      if (accept) begin
         unique case (cmd_type'(req_data.cmd))
            CMD_PUSH: begin
               // redo entries go; a mark among them is lost
               if (mark_ok_ff && (mark_ff > pos_ff)) begin
                  mark_ok_pre = 1'b0;
               end
               mark_ok_in = mark_ok_pre;
               if (pos_ff == PTR_W'(DEPTH)) begin
                  // full: drop the oldest record
                  base_in = (base_ff == IDX_W'(DEPTH - 1)) ? '0 : base_ff + 1'b1;
                  pos_pre = pos_ff - 1'b1;
                  if (mark_ok_pre && (mark_ff != '0)) begin
                     mark_in = mark_ff - 1'b1;
                  end else begin
                     mark_ok_in = 1'b0;
                  end
               end
               wr_en    = 1'b1;
               wr_idx   = slot_of(base_in, pos_pre);
               pos_in   = pos_pre + 1'b1;
               count_in = pos_pre + 1'b1;
            end
            CMD_UNDO: begin
               if (pos_ff != '0) begin
                  pos_in   = pos_ff - 1'b1;
                  rd_en    = 1'b1;
                  rd_idx   = slot_of(base_ff, pos_ff - 1'b1);
                  entry_in = 1'b1;
               end
            end
            CMD_REDO: begin
               if (pos_ff < count_ff) begin
                  pos_in   = pos_ff + 1'b1;
                  rd_en    = 1'b1;
                  rd_idx   = slot_of(base_ff, pos_ff);
                  entry_in = 1'b1;
               end
            end
            CMD_MARK: begin
               mark_in    = pos_ff;
               mark_ok_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         count_ff   <= '0;
         base_ff    <= '0;
         mark_ff    <= '0;
         mark_ok_ff <= 1'b1;
         strobe_ff  <= 1'b0;
         entry_ff   <= 1'b0;
         dirty_ff   <= 1'b0;
         undo_ff    <= 1'b0;
         redo_ff    <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         base_ff    <= base_in;
         mark_ff    <= mark_in;
         mark_ok_ff <= mark_ok_in;
         strobe_ff  <= accept;
         entry_ff   <= entry_in;
         dirty_ff   <= !(mark_ok_in && (mark_in == pos_in));
         undo_ff    <= (pos_in != '0);
         redo_ff    <= (pos_in < count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         history[wr_idx] <= make_rec(req_data);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= history[rd_idx];
      end
   end

   always_comb begin
      rsp_data                 = '0;
      rsp_data.entry_valid     = entry_ff;
      rsp_data.dirty           = dirty_ff;
      rsp_data.undo_possible   = undo_ff;
      rsp_data.redo_possible   = redo_ff;
      if (entry_ff) begin
         rsp_data.out_kind        = rd_q_ff.kind;
         rsp_data.out_cur_line    = rd_q_ff.cur_line;
         rsp_data.out_cur_column  = rd_q_ff.cur_column;
         rsp_data.out_edit_line   = rd_q_ff.edit_line;
         rsp_data.out_edit_column = rd_q_ff.edit_column;
         rsp_data.out_char        = rd_q_ff.char_code;
         rsp_data.out_new_line    = rd_q_ff.new_line;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

// ===== src/bur_checker.sv =====
// Port-level checker for the undo/redo history stack, bound to the top level.
`default_nettype none

module bur_checker
   import bur_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   // one result for every transfer, in the following cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("no result after command transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without command");

   // a push leaves something to undo and nothing to redo
   a_push_status: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_PUSH) |=>
         (rsp_data.undo_possible && !rsp_data.redo_possible && !rsp_data.entry_valid))
      else $error("bad status after push");

   a_mark_clean: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_MARK) |=> !rsp_data.dirty)
      else $error("dirty right after mark saved");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.entry_valid) |->
         (rsp_data.out_kind == '0 && rsp_data.out_cur_line == '0 &&
          rsp_data.out_edit_line == '0 && rsp_data.out_char == '0))
      else $error("record fields set without entry");

endmodule

bind bounded_undo_redo_stack bur_checker u_bur_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

// ===== tb/tb_bounded_undo_redo_stack.sv =====
// Self-checking testbench for the bounded undo/redo history stack.
module tb_bounded_undo_redo_stack;
   timeunit 1ns;
   timeprecision 1ps;

   import bur_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   bounded_undo_redo_stack dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #1 clock = ~clock;

   // predicted history: records kept as result words, in a ring of our own
   rsp_type ring_mem [DEPTH];
   int      ring_base  = 0;
   int      hist_pos   = 0;
   int      hist_count = 0;
   int      saved_at   = 0;   // -1 when the mark is lost

   rsp_type awaited_rsps [$];

   int fails      = 0;
   int checked    = 0;
   int pushes     = 0;
   int undo_hits  = 0;
   int redo_hits  = 0;
   int evictions  = 0;
   int marks_lost = 0;
   int burst_left = 0;

   function automatic rsp_type apply_history_cmd(input req_type r);
      rsp_type res;
      rsp_type rec;
      res = '0;
      case (r.cmd)
         CMD_PUSH: begin
            rec = '0;
            rec.entry_valid    = 1'b1;
            rec.out_kind       = r.edit_kind;
            rec.out_cur_line   = r.cur_line;
            rec.out_cur_column = r.cur_column;
            rec.out_edit_line  = r.edit_line;
            if (r.edit_kind != KIND_INS_NL) begin
               rec.out_edit_column = r.edit_column;
            end
            if (r.edit_kind == KIND_INS_CHAR || r.edit_kind == KIND_DEL_CHAR) begin
               rec.out_char = r.char_code;
            end
            if (r.edit_kind == KIND_INS_CHAR) begin
               rec.out_new_line = r.made_new_line;
            end
            // redo entries go; a mark among them is lost
            if (saved_at > hist_pos) begin
               saved_at = -1;
               marks_lost++;
            end
            hist_count = hist_pos;
            if (hist_count >= DEPTH) begin
               ring_base = (ring_base + 1) % DEPTH;
               hist_count--;
               hist_pos--;
               evictions++;
               if (saved_at > 0) begin
                  saved_at--;
               end else begin
                  if (saved_at == 0) marks_lost++;
                  saved_at = -1;
               end
            end
            ring_mem[(ring_base + hist_pos) % DEPTH] = rec;
            hist_pos++;
            hist_count = hist_pos;
            pushes++;
         end
         CMD_UNDO: begin
            if (hist_pos > 0) begin
               hist_pos--;
               res = ring_mem[(ring_base + hist_pos) % DEPTH];
               undo_hits++;
            end
         end
         CMD_REDO: begin
            if (hist_pos < hist_count) begin
               res = ring_mem[(ring_base + hist_pos) % DEPTH];
               hist_pos++;
               redo_hits++;
            end
         end
         default: begin
            saved_at = hist_pos;
         end
      endcase
      res.dirty         = !(saved_at >= 0 && saved_at == hist_pos);
      res.undo_possible = (hist_pos > 0);
      res.redo_possible = (hist_pos < hist_count);
      return res;
   endfunction

   function automatic void check_field(input string fname, input logic [11:0] want,
                                       input logic [11:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", fname, want, got);
         fails++;
      end
   endfunction

   function automatic void check_rsp(input rsp_type want, input rsp_type got);
      check_field("entry_valid", want.entry_valid, got.entry_valid);
      check_field("out_kind", want.out_kind, got.out_kind);
      check_field("out_cur_line", want.out_cur_line, got.out_cur_line);
      check_field("out_cur_column", want.out_cur_column, got.out_cur_column);
      check_field("out_edit_line", want.out_edit_line, got.out_edit_line);
      check_field("out_edit_column", want.out_edit_column, got.out_edit_column);
      check_field("out_char", want.out_char, got.out_char);
      check_field("out_new_line", want.out_new_line, got.out_new_line);
      check_field("dirty", want.dirty, got.dirty);
      check_field("undo_possible", want.undo_possible, got.undo_possible);
      check_field("redo_possible", want.redo_possible, got.redo_possible);
   endfunction

   // result of the previous transfer is checked before this edge's transfer is predicted
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (awaited_rsps.size() == 0) begin
               $error("result strobed with nothing awaited");
               fails++;
            end else begin
               want = awaited_rsps.pop_front();
               check_rsp(want, rsp_data);
               checked++;
            end
         end else if (rsp_strobe !== 1'b0) begin
            $error("rsp_strobe: expected 0 or 1, got %b", rsp_strobe);
            fails++;
         end
         if (start === 1'b1 && busy === 1'b0) begin
            awaited_rsps.push_back(apply_history_cmd(req_data));
         end
      end
   end

   function automatic req_type random_req();
      req_type r;
      r.cmd           = cmd_type'($urandom_range(0, 3));
      r.edit_kind     = kind_type'($urandom_range(0, 3));
      r.cur_line      = 12'($urandom);
      r.cur_column    = 12'($urandom);
      r.edit_line     = 12'($urandom);
      r.edit_column   = 12'($urandom);
      r.char_code     = 8'($urandom);
      r.made_new_line = 1'($urandom);
      return r;
   endfunction

   function automatic req_type cmd_req(input cmd_type c);
      req_type r;
      r     = random_req();
      r.cmd = c;
      return r;
   endfunction

   function automatic req_type edit_req(input kind_type k, input logic [11:0] cl,
                                        input logic [11:0] cc, input logic [11:0] el,
                                        input logic [11:0] ec, input logic [7:0] ch,
                                        input logic nl);
      req_type r;
      r.cmd           = CMD_PUSH;
      r.edit_kind     = k;
      r.cur_line      = cl;
      r.cur_column    = cc;
      r.edit_line     = el;
      r.edit_column   = ec;
      r.char_code     = ch;
      r.made_new_line = nl;
      return r;
   endfunction

   task automatic send_cmd(input req_type item);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_cycles(input int n);
      @(negedge clock);
      start    <= 1'b0;
      req_data <= random_req();
      repeat (n - 1) @(negedge clock);
   endtask

   // sender in bursts, now and then a long stretch without gaps
   task automatic send_paced(input req_type item);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 60);
         else burst_left = $urandom_range(1, 12);
         idle_cycles($urandom_range(1, 5));
      end
      send_cmd(item);
      burst_left--;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_rsps.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_cmd(cmd_req(CMD_UNDO));   // nothing to undo
      send_cmd(cmd_req(CMD_REDO));   // nothing to redo
      send_cmd(cmd_req(CMD_MARK));
      send_cmd(edit_req(KIND_INS_CHAR, '1, '1, '1, '1, '1, 1'b1));
      send_cmd(edit_req(KIND_DEL_CHAR, '1, '1, '1, '1, '1, 1'b1));
      send_cmd(edit_req(KIND_INS_NL, '1, '1, '1, '1, '1, 1'b1));
      send_cmd(edit_req(KIND_JOIN_ROW, '1, '1, '1, '1, '1, 1'b1));
      send_cmd(edit_req(KIND_INS_CHAR, '0, '0, '0, '0, '0, 1'b0));
      send_cmd(edit_req(KIND_INS_CHAR, 12'haaa, 12'h555, 12'haaa, 12'h555, 8'ha5, 1'b0));
      send_cmd(cmd_req(CMD_MARK));
      send_cmd(cmd_req(CMD_UNDO));
      send_cmd(cmd_req(CMD_UNDO));
      send_cmd(cmd_req(CMD_REDO));
      // push over a redo entry holding the mark: mark is lost
      send_cmd(edit_req(KIND_DEL_CHAR, 12'h555, 12'haaa, 12'h555, 12'haaa, 8'h5a, 1'b1));
      repeat (7) send_cmd(cmd_req(CMD_UNDO));
      send_cmd(cmd_req(CMD_REDO));
      send_cmd(cmd_req(CMD_MARK));
      send_cmd(cmd_req(CMD_REDO));
      wait_quiet();
   endtask

   // overflow the store so the oldest records go and the mark slides down then is lost
   task automatic test_full_store();
      repeat (10) send_paced(cmd_req(CMD_PUSH));
      send_paced(cmd_req(CMD_MARK));
      repeat (60) send_paced(cmd_req(CMD_PUSH));
      send_paced(cmd_req(CMD_UNDO));
      send_paced(cmd_req(CMD_UNDO));
      send_paced(cmd_req(CMD_REDO));
      send_paced(cmd_req(CMD_REDO));
      repeat (15) send_paced(cmd_req(CMD_PUSH));
      repeat (66) send_paced(cmd_req(CMD_UNDO));
      repeat (66) send_paced(cmd_req(CMD_REDO));
      wait_quiet();
   endtask

   task automatic test_random_mix(input int n);
      int mode;
      int pick;
      int push_w;
      int undo_w;
      int redo_w;
      mode = 0;
      push_w = 0;
      undo_w = 0;
      redo_w = 0;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            mode = $urandom_range(0, 2);
            case (mode)
               0: begin push_w = 60; undo_w = 15; redo_w = 15; end
               1: begin push_w = 20; undo_w = 35; redo_w = 35; end
               default: begin push_w = 35; undo_w = 25; redo_w = 25; end
            endcase
         end
         if (i == n / 2) wait_quiet();
         pick = $urandom_range(0, 99);
         if (pick < push_w) send_paced(cmd_req(CMD_PUSH));
         else if (pick < push_w + undo_w) send_paced(cmd_req(CMD_UNDO));
         else if (pick < push_w + undo_w + redo_w) send_paced(cmd_req(CMD_REDO));
         else send_paced(cmd_req(CMD_MARK));
      end
      wait_quiet();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_store();
      test_random_mix(820);
      repeat (4) @(negedge clock);
      $display("Covered %0d pushes (%0d evictions), %0d undo and %0d redo transfers",
               pushes, evictions, undo_hits, redo_hits);
      $display("returning records, %0d saved marks lost; %0d results checked.",
               marks_lost, checked);
      if (fails == 0 && awaited_rsps.size() == 0) begin
         $display("** bounded_undo_redo_stack: PASSED **");
      end else begin
         $display("** bounded_undo_redo_stack: FAILED **");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("** bounded_undo_redo_stack: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bur_pkg.sv
src/bounded_undo_redo_stack.sv
src/bur_checker.sv
tb/tb_bounded_undo_redo_stack.sv
